// ===== rtl/sal_pkg.sv =====
// ----------------------------------------------------------------------------
// sal_pkg: shared types and microprogram of the sorted array list
// Request and result payloads, control word layout, the microprogram table
// and the request dispatch table.
// ----------------------------------------------------------------------------
package sal_pkg;

  localparam int unsigned CAPACITY_DEF = 128;

  localparam int unsigned REQ_W  = 3;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned LEN_W  = 8;
  localparam int unsigned STAT_W = 2;

  // Request kinds.
  localparam logic [REQ_W-1:0] REQ_ADD  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DEL  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SRCH = 3'd2;
  localparam logic [REQ_W-1:0] REQ_READ = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLR  = 3'd4;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic signed [VAL_W-1:0] item_value;
    logic [POS_W-1:0]        entry_pos;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [POS_W-1:0]        found_pos;
    logic signed [VAL_W-1:0] entry_value;
    logic [LEN_W-1:0]        list_length;
    logic                    list_empty;
    logic                    list_full;
  } rsp_t;

  // Microprogram step addresses.
  typedef enum logic [4:0] {
    S_IDLE,
    S_ADD0, S_ADD1, S_ADD2, S_ADD3, S_ADD4, S_ADD5,
    S_DEL0, S_DEL1, S_DEL2, S_DEL3,
    S_SRCH0, S_SRCH1,
    S_RD0, S_RD1,
    S_CLR0,
    S_EMIT
  } step_e;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_ACCEPT,
    C_OUT_FREE,
    C_CNT_ZERO,
    C_CNT_FULL,
    C_EQ_MORE,
    C_NE_MORE,
    C_ORD_MORE,
    C_P_END,
    C_SHDN_MORE,
    C_SHUP_MORE,
    C_RPOS_BAD
  } cond_e;

  // Datapath actions.
  typedef enum logic [4:0] {
    A_NONE,
    A_LATCH,
    A_EMIT,
    A_E0,
    A_P_INC,
    A_ASC,
    A_P_ZERO,
    A_K_CNT,
    A_SHUP,
    A_INS,
    A_FIND_RES,
    A_SHDN,
    A_DEC,
    A_EVAL,
    A_CLR,
    A_ST_FULL,
    A_ST_EMPTY,
    A_ST_NF
  } act_e;

  // Read address sources of the entry memory.
  typedef enum logic [2:0] {
    RD_ZERO,
    RD_ONE,
    RD_P1,
    RD_P2,
    RD_K2,
    RD_CNT_M1,
    RD_RPOS
  } rd_e;

  typedef struct packed {
    cond_e cond;
    act_e  act_t;
    act_e  act_n;
    rd_e   rd;
    step_e tgt_t;
    step_e tgt_n;
  } ucode_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic             in_valid;
    logic [REQ_W-1:0] req_type;
    logic             out_free;
    logic             cnt_zero;
    logic             cnt_full;
    logic             eq_more;
    logic             ne_more;
    logic             ord_more;
    logic             p_end;
    logic             shdn_more;
    logic             shup_more;
    logic             rpos_bad;
  } flags_t;

  // Control driven by the sequencer into the datapath.
  typedef struct packed {
    act_e act;
    rd_e  rd;
    logic idle;
  } ctrl_t;

  function automatic ucode_t uw(cond_e c, act_e at, act_e an, rd_e r,
                                step_e tt, step_e tn);
    ucode_t w;
    w.cond  = c;
    w.act_t = at;
    w.act_n = an;
    w.rd    = r;
    w.tgt_t = tt;
    w.tgt_n = tn;
    return w;
  endfunction

  // The microprogram. A word jumps to tgt_t and performs act_t when its
  // condition holds, otherwise it goes to tgt_n and performs act_n.
  function automatic ucode_t ucode_word(step_e s);
    ucode_t w;
    case (s)
      S_IDLE:  w = uw(C_ACCEPT,    A_LATCH,    A_NONE,     RD_ZERO,   S_IDLE,  S_IDLE);
      // Add: order from the first differing entry, find the slot, open it.
      S_ADD0:  w = uw(C_CNT_FULL,  A_ST_FULL,  A_E0,       RD_ONE,    S_EMIT,  S_ADD1);
      S_ADD1:  w = uw(C_NE_MORE,   A_P_INC,    A_ASC,      RD_P1,     S_ADD1,  S_ADD2);
      S_ADD2:  w = uw(C_ALWAYS,    A_P_ZERO,   A_NONE,     RD_ZERO,   S_ADD3,  S_ADD3);
      S_ADD3:  w = uw(C_ORD_MORE,  A_P_INC,    A_NONE,     RD_P1,     S_ADD3,  S_ADD4);
      S_ADD4:  w = uw(C_ALWAYS,    A_K_CNT,    A_NONE,     RD_CNT_M1, S_ADD5,  S_ADD5);
      S_ADD5:  w = uw(C_SHUP_MORE, A_SHUP,     A_INS,      RD_K2,     S_ADD5,  S_EMIT);
      // Delete: find the first match, then close the gap.
      S_DEL0:  w = uw(C_CNT_ZERO,  A_ST_EMPTY, A_NONE,     RD_ZERO,   S_EMIT,  S_DEL1);
      S_DEL1:  w = uw(C_EQ_MORE,   A_P_INC,    A_FIND_RES, RD_P1,     S_DEL1,  S_DEL2);
      S_DEL2:  w = uw(C_P_END,     A_NONE,     A_NONE,     RD_P1,     S_EMIT,  S_DEL3);
      S_DEL3:  w = uw(C_SHDN_MORE, A_SHDN,     A_DEC,      RD_P2,     S_DEL3,  S_EMIT);
      // Search.
      S_SRCH0: w = uw(C_CNT_ZERO,  A_ST_EMPTY, A_NONE,     RD_ZERO,   S_EMIT,  S_SRCH1);
      S_SRCH1: w = uw(C_EQ_MORE,   A_P_INC,    A_FIND_RES, RD_P1,     S_SRCH1, S_EMIT);
      // Read entry.
      S_RD0:   w = uw(C_CNT_ZERO,  A_ST_EMPTY, A_NONE,     RD_RPOS,   S_EMIT,  S_RD1);
      S_RD1:   w = uw(C_RPOS_BAD,  A_ST_NF,    A_EVAL,     RD_RPOS,   S_EMIT,  S_EMIT);
      // Clear.
      S_CLR0:  w = uw(C_ALWAYS,    A_CLR,      A_NONE,     RD_ZERO,   S_EMIT,  S_EMIT);
      // Hand the result to the output register once it is free.
      S_EMIT:  w = uw(C_OUT_FREE,  A_EMIT,     A_NONE,     RD_ZERO,   S_IDLE,  S_EMIT);
      default: w = uw(C_ALWAYS,    A_NONE,     A_NONE,     RD_ZERO,   S_IDLE,  S_IDLE);
    endcase
    return w;
  endfunction

  // Entry step of each request kind; unused kinds go straight to the result.
  function automatic step_e dispatch(logic [REQ_W-1:0] req);
    step_e s;
    case (req)
      REQ_ADD:  s = S_ADD0;
      REQ_DEL:  s = S_DEL0;
      REQ_SRCH: s = S_SRCH0;
      REQ_READ: s = S_RD0;
      REQ_CLR:  s = S_CLR0;
      default:  s = S_EMIT;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/sal_stream_if.sv =====
// ----------------------------------------------------------------------------
// sal_stream_if: valid/ready channel
// Carries one payload of type T per request from a source to a sink.
// ----------------------------------------------------------------------------
interface sal_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/sorted_array_list_core.sv =====
// ----------------------------------------------------------------------------
// sorted_array_list_core: microcoded sorted array list
// Keeps up to CAPACITY signed 32-bit entries in sorted order and serves add,
// delete, search, read entry and clear requests, one result per request.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake      Payload
//   req_i    in   valid/ready    req_type, item_value, entry_pos
//   rsp_o    out  valid/ready    status, found_pos, entry_value, list_length,
//                                list_empty, list_full
//
// One request is in work at a time. The scans and shifts walk the entry memory
// one entry per cycle through its single read port.
// Reset empties the list at once; the entry memory is not cleared, since
// entries at or beyond the length are never used.
// The result sits in an output register: a stalled rsp_o does not keep the
// core from taking the next request, which waits only to hand over its own
// result.
//
// The microprogram in sal_pkg steers the datapath: every step selects a read
// address, tests one condition and performs one action on either branch.
// Add first learns the order of the list from the first entry and the first
// later entry that differs from it, then scans for the slot after any equal
// entries and moves the tail up one place from the top down. Delete scans for
// the first match and moves the tail down one place from the match upward.
// ----------------------------------------------------------------------------
module sorted_array_list_core #(
  parameter int unsigned CAPACITY = sal_pkg::CAPACITY_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sal_stream_if.sink   req_i,
  sal_stream_if.source rsp_o
);

  sal_pkg::flags_t flags;
  sal_pkg::ctrl_t  ctrl;

  // Sequencer: step counter and microprogram table.
  sal_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  // Datapath: entry memory, pointers, comparators and output register.
  sal_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_i),
    .rsp     (rsp_o),
    .ctrl_i  (ctrl),
    .flags_o (flags)
  );

endmodule

// ===== rtl/sal_seq.sv =====
// ----------------------------------------------------------------------------
// sal_seq: microprogram sequencer
// Step counter, control word lookup and condition select with two-way jumps.
// ----------------------------------------------------------------------------
module sal_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sal_pkg::flags_t flags_i,
  output sal_pkg::ctrl_t  ctrl_o
);

  sal_pkg::step_e  pc_q, pc_d;
  sal_pkg::ucode_t word;
  logic            taken;

  assign word = sal_pkg::ucode_word(pc_q);

  always_comb begin
    case (word.cond)
      sal_pkg::C_ALWAYS:    taken = 1'b1;
      sal_pkg::C_ACCEPT:    taken = flags_i.in_valid;
      sal_pkg::C_OUT_FREE:  taken = flags_i.out_free;
      sal_pkg::C_CNT_ZERO:  taken = flags_i.cnt_zero;
      sal_pkg::C_CNT_FULL:  taken = flags_i.cnt_full;
      sal_pkg::C_EQ_MORE:   taken = flags_i.eq_more;
      sal_pkg::C_NE_MORE:   taken = flags_i.ne_more;
      sal_pkg::C_ORD_MORE:  taken = flags_i.ord_more;
      sal_pkg::C_P_END:     taken = flags_i.p_end;
      sal_pkg::C_SHDN_MORE: taken = flags_i.shdn_more;
      sal_pkg::C_SHUP_MORE: taken = flags_i.shup_more;
      sal_pkg::C_RPOS_BAD:  taken = flags_i.rpos_bad;
      default:              taken = 1'b0;
    endcase
  end

  always_comb begin
    if (taken) begin
      pc_d = (word.cond == sal_pkg::C_ACCEPT) ? sal_pkg::dispatch(flags_i.req_type)
                                              : word.tgt_t;
    end else begin
      pc_d = word.tgt_n;
    end
  end

  assign ctrl_o.act  = taken ? word.act_t : word.act_n;
  assign ctrl_o.rd   = word.rd;
  assign ctrl_o.idle = (pc_q == sal_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= sal_pkg::S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== rtl/sal_dpath.sv =====
// ----------------------------------------------------------------------------
// sal_dpath: datapath of the sorted array list
// Entry memory with one write and one registered read port, scan pointers,
// comparators, result registers and the output register.
// ----------------------------------------------------------------------------
module sal_dpath #(
  parameter int unsigned CAPACITY = sal_pkg::CAPACITY_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  sal_stream_if.sink      req,
  sal_stream_if.source    rsp,
  input  sal_pkg::ctrl_t  ctrl_i,
  output sal_pkg::flags_t flags_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned PW = sal_pkg::POS_W;
  localparam int unsigned LW = sal_pkg::LEN_W;
  localparam int unsigned VW = sal_pkg::VAL_W;

  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] FULL = CW'(CAPACITY);
  localparam logic [CW:0]   ONE_X = (CW+1)'(1);

  logic signed [VW-1:0] mem_q [CAPACITY];
  logic signed [VW-1:0] rdata_q;
  logic [IW-1:0]        rd_addr, wr_addr;
  logic signed [VW-1:0] wr_data;
  logic                 wr_en;

  logic [CW-1:0]                cnt_q, p_q, k_q;
  logic signed [VW-1:0]         val_q, e0_q, evalue_q;
  logic [PW-1:0]                rpos_q, fpos_q;
  logic [sal_pkg::STAT_W-1:0]   status_q;
  logic                         asc_q, out_valid_q;
  sal_pkg::rsp_t                rsp_q;

  logic p_more, p_end, ord_hit, asc_d;

  assign p_more  = (p_q < cnt_q);
  assign p_end   = !p_more;
  assign ord_hit = asc_q ? (rdata_q > val_q) : (rdata_q < val_q);
  assign asc_d   = p_end ? 1'b1 : !(e0_q > rdata_q);

  always_comb begin
    case (ctrl_i.rd)
      sal_pkg::RD_ZERO:   rd_addr = '0;
      sal_pkg::RD_ONE:    rd_addr = IW'(1);
      sal_pkg::RD_P1:     rd_addr = IW'(p_q + ONE);
      sal_pkg::RD_P2:     rd_addr = IW'(p_q + ONE + ONE);
      sal_pkg::RD_K2:     rd_addr = IW'(k_q - ONE - ONE);
      sal_pkg::RD_CNT_M1: rd_addr = IW'(cnt_q - ONE);
      sal_pkg::RD_RPOS:   rd_addr = IW'(rpos_q);
      default:            rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = IW'(p_q);
    wr_data = rdata_q;
    case (ctrl_i.act)
      sal_pkg::A_SHUP: begin
        wr_en   = 1'b1;
        wr_addr = IW'(k_q);
      end
      sal_pkg::A_SHDN: begin
        wr_en = 1'b1;
      end
      sal_pkg::A_INS: begin
        wr_en   = 1'b1;
        wr_data = val_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (ctrl_i.act)
        sal_pkg::A_INS: cnt_q <= cnt_q + ONE;
        sal_pkg::A_DEC: cnt_q <= cnt_q - ONE;
        sal_pkg::A_CLR: cnt_q <= '0;
        default: ;
      endcase
      if (ctrl_i.act == sal_pkg::A_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.act)
      sal_pkg::A_LATCH: begin
        val_q    <= req.data.item_value;
        rpos_q   <= req.data.entry_pos;
        status_q <= sal_pkg::ST_OK;
        fpos_q   <= '0;
        evalue_q <= '0;
        p_q      <= '0;
      end
      sal_pkg::A_E0: begin
        e0_q <= rdata_q;
        p_q  <= ONE;
      end
      sal_pkg::A_P_INC:  p_q   <= p_q + ONE;
      sal_pkg::A_ASC:    asc_q <= asc_d;
      sal_pkg::A_P_ZERO: p_q   <= '0;
      sal_pkg::A_K_CNT:  k_q   <= cnt_q;
      sal_pkg::A_SHUP:   k_q   <= k_q - ONE;
      sal_pkg::A_SHDN:   p_q   <= p_q + ONE;
      sal_pkg::A_FIND_RES: begin
        if (p_end) begin
          status_q <= sal_pkg::ST_NOT_FOUND;
        end else begin
          fpos_q <= PW'(p_q);
        end
      end
      sal_pkg::A_EVAL:     evalue_q <= rdata_q;
      sal_pkg::A_ST_FULL:  status_q <= sal_pkg::ST_FULL;
      sal_pkg::A_ST_EMPTY: status_q <= sal_pkg::ST_EMPTY;
      sal_pkg::A_ST_NF:    status_q <= sal_pkg::ST_NOT_FOUND;
      sal_pkg::A_EMIT: begin
        rsp_q.status      <= status_q;
        rsp_q.found_pos   <= fpos_q;
        rsp_q.entry_value <= evalue_q;
        rsp_q.list_length <= LW'(cnt_q);
        rsp_q.list_empty  <= (cnt_q == '0);
        rsp_q.list_full   <= (cnt_q == FULL);
      end
      default: ;
    endcase
  end

  assign req.ready = ctrl_i.idle;
  assign rsp.valid = out_valid_q;
  assign rsp.data  = rsp_q;

  assign flags_o.in_valid  = req.valid;
  assign flags_o.req_type  = req.data.req_type;
  assign flags_o.out_free  = !out_valid_q || rsp.ready;
  assign flags_o.cnt_zero  = (cnt_q == '0);
  assign flags_o.cnt_full  = (cnt_q >= FULL);
  assign flags_o.eq_more   = p_more && (rdata_q != val_q);
  assign flags_o.ne_more   = p_more && (rdata_q == e0_q);
  assign flags_o.ord_more  = p_more && !ord_hit;
  assign flags_o.p_end     = p_end;
  assign flags_o.shdn_more = (({1'b0, p_q} + ONE_X) < {1'b0, cnt_q});
  assign flags_o.shup_more = (k_q > p_q);
  assign flags_o.rpos_bad  = ({{CW{1'b0}}, rpos_q} >= {{PW{1'b0}}, cnt_q});

endmodule

// ===== rtl/sal_checker.sv =====
// ----------------------------------------------------------------------------
// sal_checker: port checks of the sorted array list
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module sal_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_ready_i,
  input logic          rsp_valid_i,
  input logic          rsp_ready_i,
  input sal_pkg::rsp_t rsp_data_i
);

  // A stalled result stays offered.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_data_i))
    else $error("result payload changed while stalled");

  // A request is worked on alone: no second request in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in work");

  // An ignored add only happens on a full list.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_data_i.status == sal_pkg::ST_FULL) |-> rsp_data_i.list_full)
    else $error("full status on a list that is not full");

  // The empty status only happens on an empty list.
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_data_i.status == sal_pkg::ST_EMPTY) |-> rsp_data_i.list_empty)
    else $error("empty status on a list that is not empty");

endmodule

bind sorted_array_list_core sal_checker u_sal_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

// ===== tb/sorted_list_checker.sv =====
// ----------------------------------------------------------------------------
// sorted_list_checker: result checker for the sorted array list
// Watches both channels of the core, keeps its own copy of the sorted list to
// predict each result, and compares every delivered result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_list_checker #(
  parameter int unsigned CAPACITY = sal_pkg::CAPACITY_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic          req_ready_i,
  input  sal_pkg::req_t req_data_i,
  input  logic          rsp_valid_i,
  input  logic          rsp_ready_i,
  input  sal_pkg::rsp_t rsp_data_i,
  output int unsigned   fail_count_o,
  output int unsigned   pending_o,
  output int unsigned   checked_o,
  output int unsigned   peak_len_o,
  output int unsigned   full_refusals_o
);

  localparam int unsigned VW = sal_pkg::VAL_W;

  logic signed [VW-1:0] shadow_entries [CAPACITY];
  int unsigned          shadow_len = 0;
  sal_pkg::rsp_t        expected_rsp_q [$];
  sal_pkg::rsp_t        want;
  sal_pkg::rsp_t        pred;

  initial begin
    fail_count_o    = 0;
    pending_o       = 0;
    checked_o       = 0;
    peak_len_o      = 0;
    full_refusals_o = 0;
  end

  function automatic bit locate(input logic signed [VW-1:0] v,
                                output int unsigned pos);
    pos = 0;
    for (int unsigned i = 0; i < shadow_len; i++) begin
      if (shadow_entries[i] == v) begin
        pos = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Applies one request to the shadow list and works out its result.
  task automatic apply_request(input sal_pkg::req_t r, output sal_pkg::rsp_t o);
    int unsigned          i;
    int unsigned          k;
    int unsigned          pos;
    logic                 ascending;
    logic signed [VW-1:0] v;
    v = r.item_value;
    o = '0;
    o.status = sal_pkg::ST_OK;
    case (r.req_type)
      sal_pkg::REQ_ADD: begin
        if (shadow_len >= CAPACITY) begin
          o.status = sal_pkg::ST_FULL;
          full_refusals_o++;
        end else begin
          // The order comes from the first entry and the first one unlike it.
          ascending = 1'b1;
          for (i = 1; i < shadow_len; i++) begin
            if (shadow_entries[i] != shadow_entries[0]) begin
              ascending = !(shadow_entries[0] > shadow_entries[i]);
              break;
            end
          end
          for (i = 0; i < shadow_len; i++) begin
            if (ascending ? (shadow_entries[i] > v) : (shadow_entries[i] < v)) break;
          end
          for (k = shadow_len; k > i; k--) shadow_entries[k] = shadow_entries[k-1];
          shadow_entries[i] = v;
          shadow_len++;
        end
      end
      sal_pkg::REQ_DEL: begin
        if (shadow_len == 0) begin
          o.status = sal_pkg::ST_EMPTY;
        end else if (locate(v, pos)) begin
          for (k = pos; k + 1 < shadow_len; k++) shadow_entries[k] = shadow_entries[k+1];
          shadow_len--;
          o.found_pos = pos[sal_pkg::POS_W-1:0];
        end else begin
          o.status = sal_pkg::ST_NOT_FOUND;
        end
      end
      sal_pkg::REQ_SRCH: begin
        if (shadow_len == 0) begin
          o.status = sal_pkg::ST_EMPTY;
        end else if (locate(v, pos)) begin
          o.found_pos = pos[sal_pkg::POS_W-1:0];
        end else begin
          o.status = sal_pkg::ST_NOT_FOUND;
        end
      end
      sal_pkg::REQ_READ: begin
        if (shadow_len == 0) begin
          o.status = sal_pkg::ST_EMPTY;
        end else if (r.entry_pos < shadow_len) begin
          o.entry_value = shadow_entries[r.entry_pos];
        end else begin
          o.status = sal_pkg::ST_NOT_FOUND;
        end
      end
      sal_pkg::REQ_CLR: begin
        shadow_len = 0;
      end
      default: begin
      end
    endcase
    o.list_length = shadow_len[sal_pkg::LEN_W-1:0];
    o.list_empty  = (shadow_len == 0);
    o.list_full   = (shadow_len == CAPACITY);
    if (shadow_len > peak_len_o) peak_len_o = shadow_len;
  endtask

  task automatic check_field(input string name, input logic [VW-1:0] want_v,
                             input logic [VW-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, $signed(want_v), $signed(got_v));
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_len = 0;
      expected_rsp_q.delete();
      pending_o = 0;
    end else begin
      // A result always belongs to an earlier request, so check it first.
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          $error("result delivered with no request outstanding");
          fail_count_o++;
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("status", VW'(want.status), VW'(rsp_data_i.status));
          check_field("found_pos", VW'(want.found_pos), VW'(rsp_data_i.found_pos));
          check_field("entry_value", want.entry_value, rsp_data_i.entry_value);
          check_field("list_length", VW'(want.list_length),
                      VW'(rsp_data_i.list_length));
          check_field("list_empty", VW'(want.list_empty), VW'(rsp_data_i.list_empty));
          check_field("list_full", VW'(want.list_full), VW'(rsp_data_i.list_full));
          checked_o++;
        end
      end
      if (req_valid_i && req_ready_i) begin
        apply_request(req_data_i, pred);
        expected_rsp_q.push_back(pred);
      end
      pending_o = expected_rsp_q.size();
    end
  end

endmodule

// ===== tb/tb_sorted_array_list_core.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_array_list_core: testbench of the sorted array list core
// Sends a directed opening sequence followed by random request mixes under
// four idling modes, while a checker beside the core predicts and compares
// every result. One long result stall forces the core to back up its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_array_list_core;

  localparam int unsigned CAPACITY    = sal_pkg::CAPACITY_DEF;
  localparam int unsigned RESET_LEN   = 12;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned DRAIN_WAIT  = 2 * CAPACITY + 16;
  localparam int unsigned LIMIT       = 1_500_000;

  localparam int unsigned RW = sal_pkg::REQ_W;
  localparam int unsigned VW = sal_pkg::VAL_W;
  localparam int unsigned PW = sal_pkg::POS_W;

  // Request kinds the core does not define; they still get a result.
  localparam logic [RW-1:0] REQ_RSVD_LO = 3'd5;
  localparam logic [RW-1:0] REQ_RSVD_HI = 3'd7;

  localparam logic signed [VW-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VW-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  logic clk;
  logic rst_n;

  sal_stream_if #(.T(sal_pkg::req_t)) req_if ();
  sal_stream_if #(.T(sal_pkg::rsp_t)) rsp_if ();

  sorted_array_list_core #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned peak_len;
  int unsigned full_refusals;

  sorted_list_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .req_valid_i    (req_if.valid),
    .req_ready_i    (req_if.ready),
    .req_data_i     (req_if.data),
    .rsp_valid_i    (rsp_if.valid),
    .rsp_ready_i    (rsp_if.ready),
    .rsp_data_i     (rsp_if.data),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .peak_len_o     (peak_len),
    .full_refusals_o(full_refusals)
  );

  // Idling knobs, changed by the stimulus between phases.
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  bit          hold_go      = 1'b0;
  logic        rsp_hold;
  int unsigned sent         = 0;
  int unsigned cycle_cnt    = 0;

  // Recently added values, so that deletes and searches often find a match.
  logic signed [VW-1:0] recent_vals [16];
  int unsigned          recent_idx = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random stalls at the rate of the current phase, and a long
  // hold-off once the hold process raises rsp_hold.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // The long hold-off counts its own cycles. While it lasts, the core fills its
  // output register and the request in work, and then must refuse requests.
  initial begin
    rsp_hold <= 1'b0;
    wait (hold_go);
    @(posedge clk);
    rsp_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rsp_hold <= 1'b0;
  end

  // Offers one request and returns at the clock edge that accepts it. The
  // valid line is touched once per edge: either lowered for a gap or raised
  // with the new payload.
  task automatic send_request(input logic [RW-1:0] kind,
                              input logic signed [VW-1:0] value,
                              input logic [PW-1:0] pos);
    sal_pkg::req_t item;
    item.req_type   = kind;
    item.item_value = value;
    item.entry_pos  = pos;
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= item;
    do @(posedge clk); while (!req_if.ready);
    sent++;
  endtask

  // Values lean toward a small range so that duplicates and matches are common,
  // with the signed extremes and full-width random values mixed in.
  function automatic logic signed [VW-1:0] pick_value(input bit reuse);
    int unsigned          q;
    logic signed [VW-1:0] v;
    q = $urandom_range(9);
    if (q < 4) begin
      v = $urandom_range(16) - 8;
    end else if (q == 4) begin
      case ($urandom_range(3))
        0:       v = VAL_MIN;
        1:       v = VAL_MAX;
        2:       v = -1;
        default: v = 0;
      endcase
    end else if (q < 8 && reuse) begin
      v = recent_vals[$urandom_range(15)];
    end else begin
      v = $urandom();
    end
    return v;
  endfunction

  task automatic send_add(input logic signed [VW-1:0] value);
    recent_vals[recent_idx] = value;
    recent_idx = (recent_idx + 1) % 16;
    send_request(sal_pkg::REQ_ADD, value, PW'($urandom_range(127)));
  endtask

  // One random request; add_pct sets how hard the list is pushed to grow.
  task automatic send_random(input int unsigned add_pct);
    int unsigned   r;
    logic [PW-1:0] pos;
    pos = $urandom_range(1) ? PW'($urandom_range(127)) : PW'($urandom_range(15));
    if ($urandom_range(99) < add_pct) begin
      send_add(pick_value(1'b0));
    end else begin
      r = $urandom_range(99);
      if (r < 35)      send_request(sal_pkg::REQ_DEL, pick_value(1'b1), pos);
      else if (r < 65) send_request(sal_pkg::REQ_SRCH, pick_value(1'b1), pos);
      else if (r < 92) send_request(sal_pkg::REQ_READ, pick_value(1'b0), pos);
      else if (r < 96) send_request(sal_pkg::REQ_CLR, pick_value(1'b0), pos);
      else             send_request(RW'($urandom_range(REQ_RSVD_HI, REQ_RSVD_LO)),
                                    pick_value(1'b0), pos);
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) recent_vals[i] = '0;
    rst_n        <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: search, delete and read on an empty list, the unused kinds,
    // the signed extremes with a duplicate, reads inside and past the end,
    // first-match search and delete at both ends, a miss, then clear.
    send_request(sal_pkg::REQ_SRCH, 0, 0);
    send_request(sal_pkg::REQ_DEL, 5, 0);
    send_request(sal_pkg::REQ_READ, 0, 0);
    send_request(REQ_RSVD_LO, VAL_MAX, 7'h7F);
    send_request(REQ_RSVD_HI, VAL_MIN, 0);
    send_add(VAL_MAX);
    send_add(VAL_MIN);
    send_add(0);
    send_add(0);
    send_add(-1);
    send_request(sal_pkg::REQ_READ, 0, 0);
    send_request(sal_pkg::REQ_READ, 0, 4);
    send_request(sal_pkg::REQ_READ, 0, 5);
    send_request(sal_pkg::REQ_READ, 0, 7'h7F);
    send_request(sal_pkg::REQ_SRCH, 0, 0);
    send_request(sal_pkg::REQ_SRCH, 12345, 0);
    send_request(sal_pkg::REQ_DEL, 0, 0);
    send_request(sal_pkg::REQ_DEL, VAL_MIN, 0);
    send_request(sal_pkg::REQ_DEL, VAL_MAX, 0);
    send_request(sal_pkg::REQ_DEL, 77, 0);
    send_request(sal_pkg::REQ_CLR, VAL_MAX, 7'h7F);
    send_request(sal_pkg::REQ_READ, 0, 0);
    send_add(7);

    // Phase one, no idling: the long result hold-off starts while the list is
    // filled past capacity, so adds on a full list are refused, then a mix.
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_go      = 1'b1;
    repeat (CAPACITY + 12) send_add(pick_value(1'b0));
    repeat (45) send_random(40);

    // Phase two: the sender idles most of the time.
    tx_idle_pct  = 67;
    rx_stall_pct = 0;
    repeat (180) send_random(45);

    // Phase three: the receiver stalls most of the time.
    tx_idle_pct  = 0;
    rx_stall_pct = 67;
    repeat (180) send_random(35);

    // Phase four: light idling on both sides.
    tx_idle_pct  = 14;
    rx_stall_pct = 14;
    repeat (180) send_random(40);

    req_if.valid <= 1'b0;

    // Drain: poll away from the active edge so the count is settled.
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d requests over four idling modes; %0d results checked.",
             sent, checked);
    $display("Longest list held %0d entries; %0d adds were refused on a full list.",
             peak_len, full_refusals);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
